FILE: design/rsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types, codes and constants of the restart supervisor watchdog.
// ----------------------------------------------------------------------------
package rsw_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned TimeBitsDef   = 32;

  localparam int unsigned OpW      = 3;
  localparam int unsigned MinW     = 11;
  localparam int unsigned IdW      = 5;
  localparam int unsigned CauseW   = 2;
  localparam int unsigned HbTimeW  = 12;
  localparam int unsigned Min60W   = 17;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [HbTimeW-1:0] HbTimeoutRst   = 12'd60;
  localparam logic [MinW-1:0]    BootMinRst     = 11'd480;
  localparam logic [MinW-1:0]    AbnormalMinRst = 11'd2;
  localparam logic [MinW-1:0]    GuardMinRst    = 11'd2;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_HEARTBEAT = 3'd1,
    OP_ABNORMAL  = 3'd2,
    OP_CREATE    = 3'd3,
    OP_RESOLVE   = 3'd4,
    OP_POSTPONE  = 3'd5
  } op_e;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_HEARTBEAT = 2'd1,
    CAUSE_DEADLINE  = 2'd2,
    CAUSE_ENTRY     = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    REG_HB_TIMEOUT  = 2'd0,
    REG_BOOT_MIN    = 2'd1,
    REG_ABNORMAL    = 2'd2,
    REG_GUARD_MIN   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [HbTimeW-1:0] hb_timeout_s;
    logic [MinW-1:0]    boot_restart_min;
    logic [MinW-1:0]    abnormal_restart_min;
    logic [MinW-1:0]    postpone_guard_min;
  } cfg_t;

  // Minutes to seconds: m*60 = m*64 - m*4.
  function automatic logic [Min60W-1:0] min_to_sec(input logic [MinW-1:0] m);
    logic [Min60W-1:0] m64;
    logic [Min60W-1:0] m4;
    m64 = {m, 6'b0};
    m4  = {4'b0, m, 2'b0};
    return m64 - m4;
  endfunction

endpackage
`default_nettype wire

FILE: design/rsw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_if
// Valid/ready channels of the supervisor: event items in, result items out.
// ----------------------------------------------------------------------------
interface rsw_in_if;
  import rsw_pkg::*;

  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic            abnormal_flag;
  logic [MinW-1:0] minutes;
  logic [IdW-1:0]  entry_id;

  modport source (output valid, output operation, output abnormal_flag,
                  output minutes, output entry_id, input ready);
  modport sink   (input valid, input operation, input abnormal_flag,
                  input minutes, input entry_id, output ready);
endinterface

interface rsw_out_if;
  import rsw_pkg::*;

  logic              valid;
  logic              ready;
  logic              restart;
  logic [CauseW-1:0] restart_cause;
  logic [IdW-1:0]    assigned_id;
  logic              resolve_hit;

  modport source (output valid, output restart, output restart_cause,
                  output assigned_id, output resolve_hit, input ready);
  modport sink   (input valid, input restart, input restart_cause,
                  input assigned_id, input resolve_hit, output ready);
endinterface
`default_nettype wire

FILE: design/rsw_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_cfg_regs
// APB-style register file holding the four timing settings of the supervisor.
// ----------------------------------------------------------------------------
module rsw_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rsw_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [rsw_pkg::CfgDataW-1:0]    pwdata,
  output logic      [rsw_pkg::CfgDataW-1:0]    prdata,
  output logic                                 pready,
  output rsw_pkg::cfg_t                        cfg_o
);
  import rsw_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e widx;
  logic     wr_en;

  assign widx   = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (widx)
        REG_HB_TIMEOUT: cfg_d.hb_timeout_s         = pwdata[HbTimeW-1:0];
        REG_BOOT_MIN:   cfg_d.boot_restart_min     = pwdata[MinW-1:0];
        REG_ABNORMAL:   cfg_d.abnormal_restart_min = pwdata[MinW-1:0];
        REG_GUARD_MIN:  cfg_d.postpone_guard_min   = pwdata[MinW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_HB_TIMEOUT: prdata = {{(CfgDataW-HbTimeW){1'b0}}, cfg_q.hb_timeout_s};
      REG_BOOT_MIN:   prdata = {{(CfgDataW-MinW){1'b0}}, cfg_q.boot_restart_min};
      REG_ABNORMAL:   prdata = {{(CfgDataW-MinW){1'b0}}, cfg_q.abnormal_restart_min};
      REG_GUARD_MIN:  prdata = {{(CfgDataW-MinW){1'b0}}, cfg_q.postpone_guard_min};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hb_timeout_s         <= HbTimeoutRst;
      cfg_q.boot_restart_min     <= BootMinRst;
      cfg_q.abnormal_restart_min <= AbnormalMinRst;
      cfg_q.postpone_guard_min   <= GuardMinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/restart_supervisor_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// restart_supervisor_watchdog
// Seconds clock, heartbeat watchdog, restart deadline, postponement window and
// a table of tracked abnormalities kept in two synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Event items enter on in_if (tick, heartbeat, abnormality, create, resolve,
//   postpone) and each one gives exactly one result item on out_if. The four
//   timing settings are to be written over the APB-style port only while the
//   block idles; the block itself does not enforce this.
//   A heartbeat, abnormality, create, resolve or unknown code finishes in the
//   execute state; a postpone passes on to the postpone state, and a tick to
//   the check state and, when the table holds entries, the scan state, with
//   one memory read per entry, pipelined with the expiry compare. The next
//   item is accepted in the cycle after the result is loaded.
//   The block works on one item at a time; the table memory has one read port,
//   which sets the scan length.
//   Reset clears the clock, heartbeat, postponement and table fill count, and
//   loads the deadline from boot_restart_min; no memory clearing pass is run.
//   A tick that raises restart returns the same state to its reset values.
//   When the receiver stalls, the result waits in the output register; a new
//   item may still be accepted, and its processing holds before its result.
// ----------------------------------------------------------------------------
module restart_supervisor_watchdog #(
  parameter int unsigned MAX_ENTRIES = rsw_pkg::MaxEntriesDef,
  parameter int unsigned TIME_BITS   = rsw_pkg::TimeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rsw_in_if.sink                             in_if,
  rsw_out_if.source                          out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rsw_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [rsw_pkg::CfgDataW-1:0]  pwdata,
  output logic      [rsw_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);
  import rsw_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > IdW) ? CntW : IdW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_POST  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic              restart;
    logic [CauseW-1:0] cause;
    logic [IdW-1:0]    assigned;
    logic              hit;
  } result_t;

  cfg_t cfg;

  rsw_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control and time state.
  state_e                state_q, state_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [TIME_BITS-1:0]  last_hb_q, last_hb_d;
  logic                  hb_seen_q, hb_seen_d;
  logic [TIME_BITS-1:0]  deadline_q, deadline_d;
  logic                  pp_active_q, pp_active_d;
  logic [TIME_BITS-1:0]  pp_until_q, pp_until_d;
  logic [CntW-1:0]       used_q, used_d;
  logic [CntW-1:0]       scan_idx_q, scan_idx_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;

  // Latched item and intermediate payload.
  logic [OpW-1:0]        op_q, op_d;
  logic                  flag_q, flag_d;
  logic [Min60W-1:0]     min60_q, min60_d;
  logic [IdW-1:0]        id_q, id_d;
  logic [TIME_BITS-1:0]  target_q, target_d;

  // Table memories: expiry time of each entry, and its resolved mark.
  logic [TIME_BITS-1:0]  due_mem [MAX_ENTRIES];
  logic                  rsv_mem [MAX_ENTRIES];
  logic                  due_we, rsv_we, rd_en;
  logic [IdxW-1:0]       due_waddr, rsv_waddr, rd_addr;
  logic [TIME_BITS-1:0]  due_wdata, due_rdata_q;
  logic                  rsv_wdata, rsv_rdata_q;

  always_ff @(posedge clk_i) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    if (rsv_we) begin
      rsv_mem[rsv_waddr] <= rsv_wdata;
    end
    if (rd_en) begin
      due_rdata_q <= due_mem[rd_addr];
      rsv_rdata_q <= rsv_mem[rd_addr];
    end
  end

  // Arithmetic shared by the states.
  logic                  out_free;
  logic [TIME_BITS-1:0]  now_inc, hb_gap, dl_diff, pp_diff, due_diff, tg_diff;
  logic [TIME_BITS-1:0]  min60_t, abn60_t, guard60_t, boot60_t, hb_limit_t;
  logic [CmpW-1:0]       id_ext, used_ext, id_dec, used_inc;
  logic                  hb_lost, dl_reached, pp_reached, entry_expired;
  result_t               res_none;

  assign out_free   = !out_valid_q || out_if.ready;
  assign now_inc    = now_q + TIME_BITS'(1);
  assign min60_t    = {{(TIME_BITS-Min60W){1'b0}}, min60_q};
  assign abn60_t    = {{(TIME_BITS-Min60W){1'b0}}, min_to_sec(cfg.abnormal_restart_min)};
  assign guard60_t  = {{(TIME_BITS-Min60W){1'b0}}, min_to_sec(cfg.postpone_guard_min)};
  assign boot60_t   = {{(TIME_BITS-Min60W){1'b0}}, min_to_sec(cfg.boot_restart_min)};
  assign hb_limit_t = {{(TIME_BITS-HbTimeW){1'b0}}, cfg.hb_timeout_s};
  assign hb_gap     = now_q - last_hb_q;
  assign dl_diff    = now_q - deadline_q;
  assign pp_diff    = now_q - pp_until_q;
  assign due_diff   = now_q - due_rdata_q;
  assign tg_diff    = target_q - deadline_q;

  // A time is reached when the wrapped difference is in the lower half.
  assign hb_lost       = hb_seen_q && (hb_gap > hb_limit_t);
  assign dl_reached    = !dl_diff[TIME_BITS-1];
  assign pp_reached    = !pp_diff[TIME_BITS-1];
  assign entry_expired = !rsv_rdata_q && !due_diff[TIME_BITS-1];

  assign id_ext   = CmpW'(id_q);
  assign used_ext = CmpW'(used_q);
  assign id_dec   = id_ext - CmpW'(1);
  assign used_inc = used_ext + CmpW'(1);
  assign res_none = '{restart: 1'b0, cause: CAUSE_NONE, assigned: '0, hit: 1'b0};

  assign in_if.ready       = (state_q == ST_IDLE);
  assign out_if.valid      = out_valid_q;
  assign out_if.restart    = res_q.restart;
  assign out_if.restart_cause = res_q.cause;
  assign out_if.assigned_id   = res_q.assigned;
  assign out_if.resolve_hit   = res_q.hit;

  always_comb begin
    logic    fin;
    logic    do_restart;
    result_t res;

    fin        = 1'b0;
    do_restart = 1'b0;
    res        = res_none;

    state_d     = state_q;
    now_d       = now_q;
    last_hb_d   = last_hb_q;
    hb_seen_d   = hb_seen_q;
    deadline_d  = deadline_q;
    pp_active_d = pp_active_q;
    pp_until_d  = pp_until_q;
    used_d      = used_q;
    scan_idx_d  = scan_idx_q;
    op_d        = op_q;
    flag_d      = flag_q;
    min60_d     = min60_q;
    id_d        = id_q;
    target_d    = target_q;
    res_d       = res_q;

    due_we    = 1'b0;
    due_waddr = used_q[IdxW-1:0];
    due_wdata = now_q + min60_t;
    rsv_we    = 1'b0;
    rsv_waddr = used_q[IdxW-1:0];
    rsv_wdata = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = scan_idx_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          op_d    = in_if.operation;
          flag_d  = in_if.abnormal_flag;
          min60_d = min_to_sec(in_if.minutes);
          id_d    = in_if.entry_id;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          case (op_q)
            OP_TICK: begin
              now_d   = now_inc;
              state_d = ST_CHECK;
            end
            OP_HEARTBEAT: begin
              last_hb_d = now_q;
              hb_seen_d = 1'b1;
              fin       = 1'b1;
            end
            OP_ABNORMAL: begin
              if (flag_q) begin
                deadline_d = now_q + abn60_t;
              end
              fin = 1'b1;
            end
            OP_CREATE: begin
              if (used_q < MaxCnt) begin
                due_we       = 1'b1;
                rsv_we       = 1'b1;
                rsv_wdata    = 1'b0;
                used_d       = used_q + CntW'(1);
                res.assigned = used_inc[IdW-1:0];
              end
              fin = 1'b1;
            end
            OP_RESOLVE: begin
              if ((id_ext != '0) && (id_ext <= used_ext)) begin
                rsv_we    = 1'b1;
                rsv_waddr = id_dec[IdxW-1:0];
                rsv_wdata = 1'b1;
                res.hit   = 1'b1;
              end
              fin = 1'b1;
            end
            OP_POSTPONE: begin
              target_d    = now_q + min60_t;
              pp_until_d  = now_q + guard60_t;
              pp_active_d = 1'b1;
              state_d     = ST_POST;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_POST: begin
        // A postpone only moves the deadline later, never earlier.
        if (!tg_diff[TIME_BITS-1]) begin
          deadline_d = target_q;
        end
        fin = 1'b1;
      end

      ST_CHECK: begin
        if (pp_active_q) begin
          if (pp_reached) begin
            pp_active_d = 1'b0;
          end
          fin = 1'b1;
        end else if (hb_lost) begin
          res.cause  = CAUSE_HEARTBEAT;
          do_restart = 1'b1;
        end else if (dl_reached) begin
          res.cause  = CAUSE_DEADLINE;
          do_restart = 1'b1;
        end else if (used_q != '0) begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          scan_idx_d = CntW'(1);
          state_d    = ST_SCAN;
        end else begin
          fin = 1'b1;
        end
      end

      ST_SCAN: begin
        // The entry read last cycle is checked while the next one is read.
        if (out_free) begin
          if (entry_expired) begin
            res.cause  = CAUSE_ENTRY;
            do_restart = 1'b1;
          end else if (scan_idx_q < used_q) begin
            rd_en      = 1'b1;
            scan_idx_d = scan_idx_q + CntW'(1);
          end else begin
            fin = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_restart) begin
      res.restart = 1'b1;
      fin         = 1'b1;
      now_d       = '0;
      last_hb_d   = '0;
      hb_seen_d   = 1'b0;
      deadline_d  = boot60_t;
      pp_active_d = 1'b0;
      pp_until_d  = '0;
      used_d      = '0;
    end

    out_valid_d = out_valid_q && !out_if.ready;
    if (fin) begin
      out_valid_d = 1'b1;
      res_d       = res;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      last_hb_q   <= '0;
      hb_seen_q   <= 1'b0;
      deadline_q  <= {{(TIME_BITS-Min60W){1'b0}}, min_to_sec(BootMinRst)};
      pp_active_q <= 1'b0;
      pp_until_q  <= '0;
      used_q      <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      last_hb_q   <= last_hb_d;
      hb_seen_q   <= hb_seen_d;
      deadline_q  <= deadline_d;
      pp_active_q <= pp_active_d;
      pp_until_q  <= pp_until_d;
      used_q      <= used_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    flag_q   <= flag_d;
    min60_q  <= min60_d;
    id_q     <= id_d;
    target_q <= target_d;
    res_q    <= res_d;
  end

endmodule
`default_nettype wire

FILE: design/rsw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_checker
// Port-level checks of the restart supervisor watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module rsw_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          restart,
  input wire logic [rsw_pkg::CauseW-1:0]    restart_cause,
  input wire logic [rsw_pkg::IdW-1:0]       assigned_id,
  input wire logic                          resolve_hit
);
  import rsw_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(restart) &&
      $stable(restart_cause) && $stable(assigned_id) && $stable(resolve_hit))
    else $error("result item changed while stalled");

  // A restart always carries a cause, and a cause only comes with a restart.
  a_cause_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (restart == (restart_cause != CAUSE_NONE)))
    else $error("restart and cause disagree");

  // A restarting tick reports nothing of create or resolve.
  a_restart_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && restart |-> (assigned_id == '0) && !resolve_hit)
    else $error("restart result carries create or resolve fields");

  // One item at a time: right after an accept the block no longer shows ready.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

bind restart_supervisor_watchdog rsw_checker u_rsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .restart       (out_if.restart),
  .restart_cause (out_if.restart_cause),
  .assigned_id   (out_if.assigned_id),
  .resolve_hit   (out_if.resolve_hit)
);
`default_nettype wire

FILE: dv/restart_supervisor_watchdog_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restart_supervisor_watchdog_test
// Self-checking bench for the restart supervisor. Event items are fed from a
// backlog with random gaps, results are taken with random stalls, and each
// result is compared with a cycle-free software copy of the supervisor that
// advances on every accepted item. Timing settings change between phases.
// ----------------------------------------------------------------------------
module restart_supervisor_watchdog_test;
  import rsw_pkg::*;

  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 238;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic            flag;
    logic [MinW-1:0] minutes;
    logic [IdW-1:0]  id;
  } event_t;

  typedef struct packed {
    logic        restart;
    cause_e      cause;
    logic [IdW-1:0] id;
    logic        hit;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata, prdata;

  rsw_in_if  ev_bus ();
  rsw_out_if res_bus ();

  restart_supervisor_watchdog dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (ev_bus),
    .out_if  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Software copy of the supervisor: settings, clock, heartbeat, deadline,
  // postponement window and the table of tracked abnormalities.
  cfg_t        cfg;
  logic [31:0] now_s, hb_at, deadline, guard_end;
  bit          hb_seen, guard_on;
  int unsigned n_used;
  logic [31:0]     ent_start [MaxEntriesDef];
  logic [MinW-1:0] ent_limit [MaxEntriesDef];
  bit              ent_done  [MaxEntriesDef];

  event_t   backlog [$];
  outcome_t awaited [$];
  event_t   in_flight;

  int unsigned fails = 0;
  int unsigned items_done = 0, ticks_done = 0, refused_creates = 0;
  int unsigned restarts_seen [4] = '{0, 0, 0, 0};
  int unsigned send_gap, stall_left;
  bit send_calm = 1'b0, take_calm = 1'b0;

  function automatic logic [31:0] sec_of(input logic [MinW-1:0] m);
    return 32'(m) * 32'd60;
  endfunction

  // A time counts as reached once the wrapped distance from it is non-negative.
  function automatic bit is_reached(input logic [31:0] t);
    logic [31:0] d;
    d = now_s - t;
    return !d[31];
  endfunction

  function automatic void clear_supervisor();
    now_s     = '0;
    hb_at     = '0;
    hb_seen   = 1'b0;
    deadline  = sec_of(cfg.boot_restart_min);
    guard_on  = 1'b0;
    guard_end = '0;
    n_used    = 0;
  endfunction

  function automatic outcome_t supervise_step(input event_t ev);
    outcome_t res;
    logic [31:0] due, target, d;
    int i;
    res = '0;
    items_done++;
    case (ev.op)
      OP_TICK: begin
        ticks_done++;
        now_s = now_s + 32'd1;
        if (!guard_on) begin
          if (hb_seen && (now_s - hb_at) > 32'(cfg.hb_timeout_s)) begin
            res.cause = CAUSE_HEARTBEAT;
          end else if (is_reached(deadline)) begin
            res.cause = CAUSE_DEADLINE;
          end else begin
            for (i = 0; i < int'(n_used); i++) begin
              due = ent_start[i] + sec_of(ent_limit[i]);
              if (!ent_done[i] && is_reached(due)) res.cause = CAUSE_ENTRY;
            end
          end
        end
        if (res.cause != CAUSE_NONE) begin
          res.restart = 1'b1;
          restarts_seen[res.cause]++;
          clear_supervisor();
        end else if (guard_on && is_reached(guard_end)) begin
          // The window closes on this tick; its checks were already skipped.
          guard_on = 1'b0;
        end
      end
      OP_HEARTBEAT: begin
        hb_at = now_s;
        hb_seen = 1'b1;
      end
      OP_ABNORMAL: begin
        if (ev.flag) deadline = now_s + sec_of(cfg.abnormal_restart_min);
      end
      OP_CREATE: begin
        if (n_used < MaxEntriesDef) begin
          ent_start[n_used] = now_s;
          ent_limit[n_used] = ev.minutes;
          ent_done[n_used]  = 1'b0;
          n_used++;
          res.id = IdW'(n_used);
        end else begin
          refused_creates++;
        end
      end
      OP_RESOLVE: begin
        if (ev.id >= 1 && ev.id <= n_used) begin
          ent_done[ev.id - 1] = 1'b1;
          res.hit = 1'b1;
        end
      end
      OP_POSTPONE: begin
        target    = now_s + sec_of(ev.minutes);
        guard_end = now_s + sec_of(cfg.postpone_guard_min);
        guard_on  = 1'b1;
        d = target - deadline;
        if (!d[31]) deadline = target;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches without any.
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int unsigned pick;
    ev.flag    = 1'($urandom_range(0, 1));
    ev.minutes = MinW'($urandom_range(0, 1440));
    ev.id      = IdW'($urandom_range(0, 16));
    pick = $urandom_range(0, 99);
    if (pick < 45) ev.op = OP_TICK;
    else if (pick < 59) ev.op = OP_HEARTBEAT;
    else if (pick < 64) ev.op = OP_ABNORMAL;
    else if (pick < 77) ev.op = OP_CREATE;
    else if (pick < 87) ev.op = OP_RESOLVE;
    else if (pick < 94) ev.op = OP_POSTPONE;
    else ev.op = OpW'($urandom_range(0, 7));
    // Short limits let entries and postponements expire within a phase.
    if ((ev.op == OP_CREATE || ev.op == OP_POSTPONE) && $urandom_range(0, 1))
      ev.minutes = MinW'($urandom_range(0, 2));
    if (ev.op == OP_RESOLVE && $urandom_range(0, 9) < 7)
      ev.id = IdW'($urandom_range(1, 4));
    return ev;
  endfunction

  function automatic void push_event(input logic [OpW-1:0] op, input logic flag,
                                     input int unsigned mins, input int unsigned id);
    event_t ev;
    ev.op = op;
    ev.flag = flag;
    ev.minutes = MinW'(mins);
    ev.id = IdW'(id);
    backlog.push_back(ev);
  endfunction

  // Event driver: predicts on acceptance, then presents the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (ev_bus.valid && ev_bus.ready) awaited.push_back(supervise_step(in_flight));
      if (!ev_bus.valid || ev_bus.ready) begin
        if (send_gap != 0) begin
          ev_bus.valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (backlog.size() != 0) begin
          in_flight = backlog.pop_front();
          ev_bus.valid         <= 1'b1;
          ev_bus.operation     <= in_flight.op;
          ev_bus.abnormal_flag <= in_flight.flag;
          ev_bus.minutes       <= in_flight.minutes;
          ev_bus.entry_id      <= in_flight.id;
          if ($urandom_range(0, 99) < 5) send_calm = !send_calm;
          send_gap = pick_idle(send_calm);
        end else begin
          ev_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int unsigned n;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (awaited.size() == 0) begin
          $error("result item arrived with no expectation pending");
          fails++;
        end else begin
          want = awaited.pop_front();
          if (res_bus.restart !== want.restart) begin
            $error("restart: expected %0d, got %0d", want.restart, res_bus.restart);
            fails++;
          end
          if (res_bus.restart_cause !== want.cause) begin
            $error("restart_cause: expected %0d, got %0d", want.cause,
                   res_bus.restart_cause);
            fails++;
          end
          if (res_bus.assigned_id !== want.id) begin
            $error("assigned_id: expected %0d, got %0d", want.id, res_bus.assigned_id);
            fails++;
          end
          if (res_bus.resolve_hit !== want.hit) begin
            $error("resolve_hit: expected %0d, got %0d", want.hit, res_bus.resolve_hit);
            fails++;
          end
        end
      end
      if (stall_left != 0) begin
        res_bus.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (res_bus.valid && res_bus.ready) begin
        if ($urandom_range(0, 99) < 5) take_calm = !take_calm;
        n = pick_idle(take_calm);
        res_bus.ready <= (n == 0);
        stall_left = (n == 0) ? 0 : n - 1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic apb_access(input bit wr, input reg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_settings();
    logic [31:0] want [4];
    logic [31:0] got;
    reg_idx_e ri;
    int k;
    want[REG_HB_TIMEOUT] = 32'(cfg.hb_timeout_s);
    want[REG_BOOT_MIN]   = 32'(cfg.boot_restart_min);
    want[REG_ABNORMAL]   = 32'(cfg.abnormal_restart_min);
    want[REG_GUARD_MIN]  = 32'(cfg.postpone_guard_min);
    for (k = 0; k < 4; k++) begin
      ri = reg_idx_e'(k);
      apb_access(1'b0, ri, '0, got);
      if (got !== want[k]) begin
        $error("%s: expected %0d, got %0d", ri.name(), want[k], got);
        fails++;
      end
    end
  endtask

  task automatic program_settings(input int unsigned hb, input int unsigned boot,
                                  input int unsigned abn, input int unsigned guard);
    logic [31:0] unused_rd;
    apb_access(1'b1, REG_HB_TIMEOUT, hb, unused_rd);
    apb_access(1'b1, REG_BOOT_MIN, boot, unused_rd);
    apb_access(1'b1, REG_ABNORMAL, abn, unused_rd);
    apb_access(1'b1, REG_GUARD_MIN, guard, unused_rd);
    cfg.hb_timeout_s         = HbTimeW'(hb);
    cfg.boot_restart_min     = MinW'(boot);
    cfg.abnormal_restart_min = MinW'(abn);
    cfg.postpone_guard_min   = MinW'(guard);
    verify_settings();
  endtask

  task automatic wait_idle();
    while (backlog.size() != 0 || ev_bus.valid || awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase, sent;
    event_t ev;
    ev_bus.valid = 1'b0;
    ev_bus.operation = OP_TICK;
    ev_bus.abnormal_flag = 1'b0;
    ev_bus.minutes = '0;
    ev_bus.entry_id = '0;
    res_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg.hb_timeout_s         = HbTimeoutRst;
    cfg.boot_restart_min     = BootMinRst;
    cfg.abnormal_restart_min = AbnormalMinRst;
    cfg.postpone_guard_min   = GuardMinRst;
    clear_supervisor();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    verify_settings();

    // Directed part with tight timing so each restart cause shows up quickly.
    // The deadline still comes from the reset value until the first restart.
    program_settings(3, 1, 0, 0);
    push_event(OpSpareLo, 1'b1, 1440, 16);
    push_event(OpSpareHi, 1'b0, 0, 0);
    push_event(OP_RESOLVE, 1'b0, 0, 0);
    push_event(OP_RESOLVE, 1'b1, 0, 1);
    push_event(OP_CREATE, 1'b0, 1440, 0);
    push_event(OP_CREATE, 1'b1, 0, 16);
    push_event(OP_RESOLVE, 1'b0, 0, 2);
    push_event(OP_RESOLVE, 1'b0, 0, 2);
    push_event(OP_RESOLVE, 1'b0, 0, 16);
    push_event(OP_ABNORMAL, 1'b0, 1440, 0);
    push_event(OP_TICK, 1'b1, 1440, 16);
    push_event(OP_HEARTBEAT, 1'b0, 0, 0);
    push_event(OP_POSTPONE, 1'b0, 0, 0);
    push_event(OP_CREATE, 1'b0, 0, 0);
    // Inside the window the expired entry is ignored; the window then closes.
    push_event(OP_TICK, 1'b0, 0, 0);
    push_event(OP_TICK, 1'b0, 0, 0);
    push_event(OP_HEARTBEAT, 1'b0, 0, 0);
    push_event(OP_POSTPONE, 1'b0, 1440, 0);
    repeat (4) push_event(OP_TICK, 1'b0, 0, 0);
    push_event(OP_ABNORMAL, 1'b1, 0, 0);
    push_event(OP_TICK, 1'b0, 0, 0);
    wait_idle();

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: program_settings(1, 1, 0, 0);
        1: program_settings(3600, 1440, 1440, 1440);
        2: program_settings(60, 480, 2, 2);
        default: program_settings($urandom_range(1, 12), $urandom_range(1, 2),
                                  $urandom_range(0, 3), $urandom_range(0, 1));
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        // Now and then a run of creates overflows the table.
        if (phase == 0 && sent == 0 || $urandom_range(0, 99) < 2) begin
          repeat (MaxEntriesDef + 1)
            push_event(OP_CREATE, 1'($urandom_range(0, 1)), $urandom_range(0, 1440),
                       $urandom_range(0, 16));
          sent += MaxEntriesDef + 1;
        end
        ev = rand_event();
        backlog.push_back(ev);
        if (ev.op <= OP_POSTPONE) sent++;
      end
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d items (%0d ticks) over %0d timing settings; %0d creates hit a full table.",
             items_done, ticks_done, NumPhases + 1, refused_creates);
    $display("Restarts: %0d heartbeat lost, %0d deadline, %0d tracked entry.",
             restarts_seen[CAUSE_HEARTBEAT], restarts_seen[CAUSE_DEADLINE],
             restarts_seen[CAUSE_ENTRY]);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
